// File: design/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// shared constants, types and tables for the euler to quaternion pipeline
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int CW            = 28;   // cordic datapath width, q.24 with headroom
    localparam int PI_Q13        = 25736;
    localparam int GAIN_Q24      = 10188014;
    localparam int OUT_MAX       = 16384;

    typedef logic signed [15:0]   angle_t;
    typedef logic signed [15:0]   comp_t;
    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t c;
        cval_t s;
    } trig_t;

    function automatic cval_t atan_q24(input int i);
        cval_t r;
        case (i)
            0:  r = CW'(13176795);
            1:  r = CW'(7778716);
            2:  r = CW'(4110060);
            3:  r = CW'(2086331);
            4:  r = CW'(1047214);
            5:  r = CW'(524117);
            6:  r = CW'(262123);
            7:  r = CW'(131069);
            default: r = (i < ATAN_ENTRIES) ? (cval_t'(1) <<< (24 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

// File: design/e2q_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_in_if / quat_out_if
// valid/ready channels for angle beats and quaternion beats
// ----------------------------------------------------------------------------
interface euler_in_if import e2q_pkg::*; ();
    logic   valid;
    logic   ready;
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface quat_out_if import e2q_pkg::*; ();
    logic  valid;
    logic  ready;
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: design/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// pipelined rotation-mode cordic, one stage per register, cosine and sine
// ----------------------------------------------------------------------------
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  angle_t angle,
    output trig_t  trig
);

    cval_t x_reg [NUM_STAGES+1];
    cval_t y_reg [NUM_STAGES+1];
    cval_t z_reg [NUM_STAGES+1];
    cval_t z_next;

    // clamp and scale to a q.24 half angle
    always_comb
    begin
        if (angle > 16'sd25736)
            z_next = cval_t'(PI_Q13) <<< 10;
        else if (angle < -16'sd25736)
            z_next = -(cval_t'(PI_Q13) <<< 10);
        else
            z_next = cval_t'(angle) <<< 10;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= cval_t'(GAIN_Q24);
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q24(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q24(i);
                end
            end
        end
    end

    assign trig.c = x_reg[NUM_STAGES];
    assign trig.s = y_reg[NUM_STAGES];

endmodule

// File: design/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// pair products, triple products, sums, rounding and saturation in five stages
// ----------------------------------------------------------------------------
module e2q_combine
    import e2q_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  trig_t roll,
    input  trig_t pitch,
    input  trig_t yaw,
    output comp_t quat_w,
    output comp_t quat_x,
    output comp_t quat_y,
    output comp_t quat_z
);

    localparam int PW = 2 * CW;
    localparam int TW = 2 * CW;

    logic signed [PW-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    cval_t cr_reg, sr_reg;
    cval_t cc_r_reg, ss_r_reg, sc_r_reg, cs_r_reg, cr2_reg, sr2_reg;
    logic signed [TW-1:0] t_reg [8];
    logic signed [TW:0]   sum_reg [4];
    comp_t q_reg [4];

    function automatic cval_t rnd24(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v + (PW'(1) <<< 23);
        return cval_t'(t >>> 24);
    endfunction

    function automatic comp_t fin(input logic signed [TW:0] v);
        logic signed [TW:0] q;
        q = (v + ((TW+1)'(1) <<< 33)) >>> 34;
        if (q > (TW+1)'(OUT_MAX))
            return comp_t'(OUT_MAX);
        if (q < -((TW+1)'(OUT_MAX)))
            return comp_t'(-OUT_MAX);
        return comp_t'(q);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // yaw by pitch products
            cc_reg <= PW'(yaw.c) * PW'(pitch.c);
            ss_reg <= PW'(yaw.s) * PW'(pitch.s);
            sc_reg <= PW'(yaw.s) * PW'(pitch.c);
            cs_reg <= PW'(yaw.c) * PW'(pitch.s);
            cr_reg <= roll.c;
            sr_reg <= roll.s;
            // rounding back to q.24
            cc_r_reg <= rnd24(cc_reg);
            ss_r_reg <= rnd24(ss_reg);
            sc_r_reg <= rnd24(sc_reg);
            cs_r_reg <= rnd24(cs_reg);
            cr2_reg  <= cr_reg;
            sr2_reg  <= sr_reg;
            // triple products in q.48
            t_reg[0] <= TW'(cc_r_reg) * TW'(cr2_reg);
            t_reg[1] <= TW'(ss_r_reg) * TW'(sr2_reg);
            t_reg[2] <= TW'(cc_r_reg) * TW'(sr2_reg);
            t_reg[3] <= TW'(ss_r_reg) * TW'(cr2_reg);
            t_reg[4] <= TW'(sc_r_reg) * TW'(sr2_reg);
            t_reg[5] <= TW'(cs_r_reg) * TW'(cr2_reg);
            t_reg[6] <= TW'(sc_r_reg) * TW'(cr2_reg);
            t_reg[7] <= TW'(cs_r_reg) * TW'(sr2_reg);
            sum_reg[0] <= (TW+1)'(t_reg[0]) + (TW+1)'(t_reg[1]);
            sum_reg[1] <= (TW+1)'(t_reg[2]) - (TW+1)'(t_reg[3]);
            sum_reg[2] <= (TW+1)'(t_reg[4]) + (TW+1)'(t_reg[5]);
            sum_reg[3] <= (TW+1)'(t_reg[6]) - (TW+1)'(t_reg[7]);
            for (int k = 0; k < 4; k++)
                q_reg[k] <= fin(sum_reg[k]);
        end
    end

    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

endmodule

// File: design/euler_angles_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// zyx euler angles to unit quaternion, fully pipelined
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | format
//  in_ch   | in  | roll/pitch/yaw_angle             | signed q3.13
//  out_ch  | out | quat_w / quat_x / quat_y / quat_z | signed q1.14
//
//  one beat per cycle unless the output stalls; the pipe is built from
//  1 clamp stage, one per cordic stage and 5 product and rounding stages
//  the whole pipe advances when the output register is empty or taken,
//  so a stalled result holds every stage and nothing is lost or repeated
//  reset clears only the valid bits
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion
    import e2q_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    euler_in_if.sink        in_ch,
    quat_out_if.source      out_ch
);

    localparam int DEPTH = NUM_STAGES + 6;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             adv;
    trig_t            roll_trig, pitch_trig, yaw_trig;

    // pipe moves when the last stage is empty or being taken
    assign adv         = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign vld_next    = {vld_reg[DEPTH-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    e2q_cordic u_roll  (.clk(clk), .en(adv), .angle(in_ch.roll_angle),  .trig(roll_trig));
    e2q_cordic u_pitch (.clk(clk), .en(adv), .angle(in_ch.pitch_angle), .trig(pitch_trig));
    e2q_cordic u_yaw   (.clk(clk), .en(adv), .angle(in_ch.yaw_angle),   .trig(yaw_trig));

    e2q_combine u_comb (
        .clk    (clk),
        .en     (adv),
        .roll   (roll_trig),
        .pitch  (pitch_trig),
        .yaw    (yaw_trig),
        .quat_w (out_ch.quat_w),
        .quat_x (out_ch.quat_x),
        .quat_y (out_ch.quat_y),
        .quat_z (out_ch.quat_z)
    );

    assign out_ch.valid = vld_reg[DEPTH-1];

endmodule
